// ===== rtl/core/afam_pkg.sv =====
// afam_pkg: shared types, constants and the cordic arctangent table for the
// attitude_from_accel_mag block. No dependencies.
`timescale 1ns / 1ps

package afam_pkg;

    // cordic operating mode
    typedef enum logic
    {
        CORDIC_VECTOR,
        CORDIC_ROTATE
    } cordic_mode_t;

    // binary angles, 2^31 = pi
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // inverse cordic gain, Q30
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;

    // configuration register indexes
    localparam int          CFG_ADDR_BITS = 1;
    localparam int          CFG_DATA_BITS = 16;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NORTH_X = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NORTH_Y = 1'b1;

    // atan(2^-i) as a binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            5'd30:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/afam_cordic.sv =====
// afam_cordic: unrolled cordic pipeline, vectoring or rotation mode, one
// iteration per register stage, with a sideband carried along.
// Depends on afam_pkg.
`timescale 1ns / 1ps

module afam_cordic #(
    parameter afam_pkg::cordic_mode_t MODE = afam_pkg::CORDIC_VECTOR,
    parameter int XW     = 35,
    parameter int STAGES = 16,
    parameter int SBW    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic [31:0]          angle_in,
    input  logic [SBW-1:0]       side_in,
    output logic                 valid_out,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic [31:0]          angle_out,
    output logic [SBW-1:0]       side_out
);

    localparam int   ZW        = 34;
    localparam logic IS_VECTOR = (MODE == afam_pkg::CORDIC_VECTOR);

    logic                 valid_reg [0:STAGES];
    logic signed [XW-1:0] x_reg     [0:STAGES];
    logic signed [XW-1:0] y_reg     [0:STAGES];
    logic signed [ZW-1:0] z_reg     [0:STAGES];
    logic                 flag_reg  [0:STAGES];
    logic [SBW-1:0]       side_reg  [0:STAGES];

    logic signed [XW-1:0] x0_next;
    logic signed [XW-1:0] y0_next;
    logic signed [ZW-1:0] z0_next;
    logic                 flag0_next;
    logic [31:0]          rot_sum;
    logic [31:0]          rot_angle;

    logic                 valid_out_reg;
    logic signed [XW-1:0] x_out_reg;
    logic signed [XW-1:0] y_out_reg;
    logic [31:0]          angle_out_reg;
    logic [SBW-1:0]       side_out_reg;

    // pre-rotation: vectoring folds the left half plane, rotation folds
    // angles outside +-pi/2 and negates the result afterwards
    always_comb
    begin
        x0_next    = x_in;
        y0_next    = y_in;
        z0_next    = '0;
        flag0_next = 1'b0;
        rot_sum    = angle_in + afam_pkg::QUARTER_TURN;
        rot_angle  = angle_in;
        if (IS_VECTOR)
        begin
            flag0_next = (x_in == '0) && (y_in == '0);
            if (x_in[XW-1])
            begin
                x0_next = -x_in;
                y0_next = -y_in;
                z0_next = ZW'(afam_pkg::HALF_TURN);
            end
        end
        else
        begin
            flag0_next = rot_sum[31];
            if (rot_sum[31])
            begin
                rot_angle = angle_in + afam_pkg::HALF_TURN;
            end
            x0_next = XW'(afam_pkg::INV_GAIN_Q30);
            y0_next = '0;
            z0_next = ZW'(signed'(rot_angle));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        flag_reg[0] <= flag0_next;
        side_reg[0] <= side_in;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] step;
        logic                 sel;

        assign dx   = y_reg[i] >>> i;
        assign dy   = x_reg[i] >>> i;
        assign step = ZW'(afam_pkg::atan_entry(5'(i)));
        // sel: rotate clockwise, angle accumulator grows
        assign sel  = IS_VECTOR ? !y_reg[i][XW-1] : z_reg[i][ZW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= sel ? x_reg[i] + dx : x_reg[i] - dx;
            y_reg[i+1]    <= sel ? y_reg[i] - dy : y_reg[i] + dy;
            z_reg[i+1]    <= sel ? z_reg[i] + step : z_reg[i] - step;
            flag_reg[i+1] <= flag_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    // post stage: zero vector gives zero, folded rotation is negated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out_reg <= 1'b0;
        end
        else
        begin
            valid_out_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        side_out_reg <= side_reg[STAGES];
        if (IS_VECTOR)
        begin
            x_out_reg     <= flag_reg[STAGES] ? '0 : x_reg[STAGES];
            y_out_reg     <= y_reg[STAGES];
            angle_out_reg <= flag_reg[STAGES] ? '0 : z_reg[STAGES][31:0];
        end
        else
        begin
            x_out_reg     <= flag_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
            y_out_reg     <= flag_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
            angle_out_reg <= z_reg[STAGES][31:0];
        end
    end

    assign valid_out = valid_out_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign angle_out = angle_out_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/core/attitude_from_accel_mag.sv =====
// attitude_from_accel_mag: tilt-compensated compass, roll/pitch/yaw and
// quaternion from one accelerometer and magnetometer sample.
// Depends on afam_pkg and afam_cordic.
`timescale 1ns / 1ps

// A sample transfer is taken at every clock edge where start is high; busy
// is always low, so one sample per clock is sustained with no gaps. Each
// sample returns exactly one result, shown for one cycle with done high,
// after it has passed through five unrolled cordic pipelines in series
// (roll, pitch, sin/cos of roll and pitch, yaw, and the half-angle sin/cos),
// each CORDIC_STAGES + 2 deep, and the multiplier stages between them. The
// receiver cannot hold results off, and none is needed: the pipeline never
// stalls. Write the north reference through the cfg port only while no
// sample is in flight. Angles are binary, 2^15 = pi at ANGLE_BITS = 16;
// quaternion parts are Q2.14, clamped to +-1.0.

module attitude_from_accel_mag #(
    parameter int SAMPLE_BITS   = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample command
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [SAMPLE_BITS-1:0]         accel_x,
    input  logic signed [SAMPLE_BITS-1:0]         accel_y,
    input  logic signed [SAMPLE_BITS-1:0]         accel_z,
    input  logic signed [SAMPLE_BITS-1:0]         mag_x,
    input  logic signed [SAMPLE_BITS-1:0]         mag_y,
    input  logic signed [SAMPLE_BITS-1:0]         mag_z,
    // configuration writes
    input  logic                                  cfg_write,
    input  logic [afam_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [afam_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // result
    output logic                                  done,
    output logic signed [15:0]                    roll_angle,
    output logic signed [15:0]                    pitch_angle,
    output logic signed [15:0]                    yaw_angle,
    output logic signed [15:0]                    quat_x,
    output logic signed [15:0]                    quat_y,
    output logic signed [15:0]                    quat_z,
    output logic signed [15:0]                    quat_w
);

    // sample scale to 2^31 full scale
    localparam int SAMPLE_SHIFT = 32 - SAMPLE_BITS;
    // output angle rounding
    localparam int          ANG_SHIFT = 32 - ANGLE_BITS;
    localparam logic [32:0] ANG_ROUND = 33'((64'd1 << ANG_SHIFT) >> 1);
    // datapath widths: accel cordic, sin/cos, yaw cordic
    localparam int XV = 35;
    localparam int XR = 33;
    localparam int XY = 56;
    localparam int LATENCY = 5 * CORDIC_STAGES + 19;

    localparam logic signed [31:0] INV_GAIN = signed'(afam_pkg::INV_GAIN_Q30);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] north_x_reg;
    logic signed [15:0] north_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            north_x_reg <= 16'sd16384;
            north_y_reg <= 16'sd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                afam_pkg::REG_NORTH_X: north_x_reg <= signed'(cfg_data);
                afam_pkg::REG_NORTH_Y: north_y_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 0: register and scale the sample
    // ------------------------------------------------------------------
    logic              s0_valid_reg;
    logic signed [31:0] ax0_reg, ay0_reg, az0_reg, mx0_reg, my0_reg, mz0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        ax0_reg <= 32'(accel_x) <<< SAMPLE_SHIFT;
        ay0_reg <= 32'(accel_y) <<< SAMPLE_SHIFT;
        az0_reg <= 32'(accel_z) <<< SAMPLE_SHIFT;
        mx0_reg <= 32'(mag_x) <<< SAMPLE_SHIFT;
        my0_reg <= 32'(mag_y) <<< SAMPLE_SHIFT;
        mz0_reg <= 32'(mag_z) <<< SAMPLE_SHIFT;
    end

    // ------------------------------------------------------------------
    // roll = atan2(ay, az), magnitude kept for pitch
    // ------------------------------------------------------------------
    logic               roll_v_valid;
    logic signed [XV-1:0] roll_mag;
    logic [31:0]        roll_v_angle;
    logic [127:0]       roll_v_side;
    logic signed [31:0] ax1, mx1, my1, mz1;

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_VECTOR),
        .XW     (XV),
        .STAGES (CORDIC_STAGES),
        .SBW    (128)
    ) u_roll_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s0_valid_reg),
        .x_in      (XV'(az0_reg)),
        .y_in      (XV'(ay0_reg)),
        .angle_in  ('0),
        .side_in   ({ax0_reg, mx0_reg, my0_reg, mz0_reg}),
        .valid_out (roll_v_valid),
        .x_out     (roll_mag),
        .y_out     (),
        .angle_out (roll_v_angle),
        .side_out  (roll_v_side)
    );

    assign {ax1, mx1, my1, mz1} = roll_v_side;

    // stage 1: remove cordic gain from |(ay, az)|
    logic               s1_valid_reg;
    logic signed [65:0] horiz_prod;
    logic signed [32:0] horiz_reg;
    logic [31:0]        roll1_reg;
    logic signed [31:0] ax1_reg, mx1_reg, my1_reg, mz1_reg;

    assign horiz_prod = roll_mag * INV_GAIN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= roll_v_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        horiz_reg <= horiz_prod[62:30];
        roll1_reg <= roll_v_angle;
        ax1_reg   <= ax1;
        mx1_reg   <= mx1;
        my1_reg   <= my1;
        mz1_reg   <= mz1;
    end

    // ------------------------------------------------------------------
    // pitch = atan2(ax, horizontal magnitude)
    // ------------------------------------------------------------------
    logic         pitch_v_valid;
    logic [31:0]  pitch_v_angle;
    logic [127:0] pitch_v_side;
    logic [31:0]  roll2;
    logic signed [31:0] mx2, my2, mz2;

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_VECTOR),
        .XW     (XV),
        .STAGES (CORDIC_STAGES),
        .SBW    (128)
    ) u_pitch_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid_reg),
        .x_in      (XV'(horiz_reg)),
        .y_in      (XV'(ax1_reg)),
        .angle_in  ('0),
        .side_in   ({roll1_reg, mx1_reg, my1_reg, mz1_reg}),
        .valid_out (pitch_v_valid),
        .x_out     (),
        .y_out     (),
        .angle_out (pitch_v_angle),
        .side_out  (pitch_v_side)
    );

    assign {roll2, mx2, my2, mz2} = pitch_v_side;

    // ------------------------------------------------------------------
    // sin/cos of roll and pitch, twin pipelines in lock step
    // ------------------------------------------------------------------
    logic               rot_r_valid, rot_p_valid;
    logic signed [XR-1:0] cr, sr, cp, sp;
    logic [95:0]        rot_r_side;
    logic [63:0]        rot_p_side;
    logic [31:0]        roll3, pitch3;
    logic signed [31:0] mx3, my3, mz3;

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_ROTATE),
        .XW     (XR),
        .STAGES (CORDIC_STAGES),
        .SBW    (96)
    ) u_roll_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (pitch_v_valid),
        .x_in      ('0),
        .y_in      ('0),
        .angle_in  (roll2),
        .side_in   ({roll2, mx2, my2}),
        .valid_out (rot_r_valid),
        .x_out     (cr),
        .y_out     (sr),
        .angle_out (),
        .side_out  (rot_r_side)
    );

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_ROTATE),
        .XW     (XR),
        .STAGES (CORDIC_STAGES),
        .SBW    (64)
    ) u_pitch_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (pitch_v_valid),
        .x_in      ('0),
        .y_in      ('0),
        .angle_in  (pitch_v_angle),
        .side_in   ({pitch_v_angle, mz2}),
        .valid_out (rot_p_valid),
        .x_out     (cp),
        .y_out     (sp),
        .angle_out (),
        .side_out  (rot_p_side)
    );

    assign {roll3, mx3, my3} = rot_r_side;
    assign {pitch3, mz3}     = rot_p_side;

    // ------------------------------------------------------------------
    // tilt compensation of the magnetometer
    // ------------------------------------------------------------------
    // stage 2: sp*sr, sp*cr
    logic               s2_valid_reg;
    logic signed [65:0] psr_prod, pcr_prod;
    logic signed [XR-1:0] psr_reg, pcr_reg, cp2_reg, cr2_reg, sr2_reg;
    logic signed [31:0] mx2_reg, my2_reg, mz2_reg;
    logic [31:0]        roll_s2_reg, pitch_s2_reg;

    assign psr_prod = sp * sr;
    assign pcr_prod = sp * cr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= rot_r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        psr_reg      <= psr_prod[62:30];
        pcr_reg      <= pcr_prod[62:30];
        cp2_reg      <= cp;
        cr2_reg      <= cr;
        sr2_reg      <= sr;
        mx2_reg      <= mx3;
        my2_reg      <= my3;
        mz2_reg      <= mz3;
        roll_s2_reg  <= roll3;
        pitch_s2_reg <= pitch3;
    end

    // stage 3: field times trig terms
    logic               s3_valid_reg;
    logic signed [65:0] t1_prod, t2_prod, t3_prod, t4_prod, t5_prod;
    logic signed [33:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [31:0]        roll_s3_reg, pitch_s3_reg;

    assign t1_prod = mx2_reg * cp2_reg;
    assign t2_prod = my2_reg * psr_reg;
    assign t3_prod = mz2_reg * pcr_reg;
    assign t4_prod = my2_reg * cr2_reg;
    assign t5_prod = mz2_reg * sr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg       <= t1_prod[63:30];
        t2_reg       <= t2_prod[63:30];
        t3_reg       <= t3_prod[63:30];
        t4_reg       <= t4_prod[63:30];
        t5_reg       <= t5_prod[63:30];
        roll_s3_reg  <= roll_s2_reg;
        pitch_s3_reg <= pitch_s2_reg;
    end

    // stage 4: horizontal field hx, hy
    logic               s4_valid_reg;
    logic signed [35:0] hx_reg, hy_reg;
    logic [31:0]        roll_s4_reg, pitch_s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hx_reg       <= 36'(t1_reg) + 36'(t2_reg) + 36'(t3_reg);
        hy_reg       <= 36'(t4_reg) - 36'(t5_reg);
        roll_s4_reg  <= roll_s3_reg;
        pitch_s4_reg <= pitch_s3_reg;
    end

    // stage 5: project onto the north reference
    logic               s5_valid_reg;
    logic signed [51:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [31:0]        roll_s5_reg, pitch_s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg       <= north_x_reg * hx_reg;
        p2_reg       <= north_y_reg * hy_reg;
        p3_reg       <= north_y_reg * hx_reg;
        p4_reg       <= north_x_reg * hy_reg;
        roll_s5_reg  <= roll_s4_reg;
        pitch_s5_reg <= pitch_s4_reg;
    end

    // stage 6: cos and sin components of heading, unnormalized
    logic               s6_valid_reg;
    logic signed [52:0] yx_reg, yy_reg;
    logic [31:0]        roll_s6_reg, pitch_s6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        yx_reg       <= 53'(p1_reg) + 53'(p2_reg);
        yy_reg       <= 53'(p3_reg) - 53'(p4_reg);
        roll_s6_reg  <= roll_s5_reg;
        pitch_s6_reg <= pitch_s5_reg;
    end

    // ------------------------------------------------------------------
    // yaw = atan2(yy, yx)
    // ------------------------------------------------------------------
    logic        yaw_valid;
    logic [31:0] yaw_angle_w;
    logic [63:0] yaw_side;
    logic [31:0] roll7, pitch7;

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_VECTOR),
        .XW     (XY),
        .STAGES (CORDIC_STAGES),
        .SBW    (64)
    ) u_yaw_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s6_valid_reg),
        .x_in      (XY'(yx_reg)),
        .y_in      (XY'(yy_reg)),
        .angle_in  ('0),
        .side_in   ({roll_s6_reg, pitch_s6_reg}),
        .valid_out (yaw_valid),
        .x_out     (),
        .y_out     (),
        .angle_out (yaw_angle_w),
        .side_out  (yaw_side)
    );

    assign {roll7, pitch7} = yaw_side;

    // ------------------------------------------------------------------
    // half-angle sin/cos, three pipelines in lock step
    // ------------------------------------------------------------------
    logic               h1_valid, h2_valid, h3_valid;
    logic signed [XR-1:0] c1, s1, c2, s2, c3, s3;
    logic [31:0]        roll8, pitch8, yaw8;

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_ROTATE),
        .XW     (XR),
        .STAGES (CORDIC_STAGES),
        .SBW    (32)
    ) u_half_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (yaw_valid),
        .x_in      ('0),
        .y_in      ('0),
        .angle_in  ({roll7[31], roll7[31:1]}),
        .side_in   (roll7),
        .valid_out (h1_valid),
        .x_out     (c1),
        .y_out     (s1),
        .angle_out (),
        .side_out  (roll8)
    );

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_ROTATE),
        .XW     (XR),
        .STAGES (CORDIC_STAGES),
        .SBW    (32)
    ) u_half_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (yaw_valid),
        .x_in      ('0),
        .y_in      ('0),
        .angle_in  ({pitch7[31], pitch7[31:1]}),
        .side_in   (pitch7),
        .valid_out (h2_valid),
        .x_out     (c2),
        .y_out     (s2),
        .angle_out (),
        .side_out  (pitch8)
    );

    afam_cordic #(
        .MODE   (afam_pkg::CORDIC_ROTATE),
        .XW     (XR),
        .STAGES (CORDIC_STAGES),
        .SBW    (32)
    ) u_half_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (yaw_valid),
        .x_in      ('0),
        .y_in      ('0),
        .angle_in  ({yaw_angle_w[31], yaw_angle_w[31:1]}),
        .side_in   (yaw_angle_w),
        .valid_out (h3_valid),
        .x_out     (c3),
        .y_out     (s3),
        .angle_out (),
        .side_out  (yaw8)
    );

    // ------------------------------------------------------------------
    // quaternion assembly
    // ------------------------------------------------------------------
    // stage 7: roll/pitch cross terms
    logic               s7_valid_reg;
    logic signed [65:0] s1c2_prod, c1s2_prod, c1c2_prod, s1s2_prod;
    logic signed [XR-1:0] s1c2_reg, c1s2_reg, c1c2_reg, s1s2_reg, c3_reg, s3_reg;
    logic [31:0]        roll_s7_reg, pitch_s7_reg, yaw_s7_reg;

    assign s1c2_prod = s1 * c2;
    assign c1s2_prod = c1 * s2;
    assign c1c2_prod = c1 * c2;
    assign s1s2_prod = s1 * s2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= h1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1c2_reg     <= s1c2_prod[62:30];
        c1s2_reg     <= c1s2_prod[62:30];
        c1c2_reg     <= c1c2_prod[62:30];
        s1s2_reg     <= s1s2_prod[62:30];
        c3_reg       <= c3;
        s3_reg       <= s3;
        roll_s7_reg  <= roll8;
        pitch_s7_reg <= pitch8;
        yaw_s7_reg   <= yaw8;
    end

    // stage 8: products with the yaw half angle
    logic               s8_valid_reg;
    logic signed [65:0] qa_prod, qb_prod, qc_prod, qd_prod;
    logic signed [65:0] qe_prod, qf_prod, qg_prod, qh_prod;
    logic signed [33:0] qa_reg, qb_reg, qc_reg, qd_reg, qe_reg, qf_reg, qg_reg, qh_reg;
    logic [31:0]        roll_s8_reg, pitch_s8_reg, yaw_s8_reg;

    assign qa_prod = s1c2_reg * c3_reg;
    assign qb_prod = c1s2_reg * s3_reg;
    assign qc_prod = s1c2_reg * s3_reg;
    assign qd_prod = c1s2_reg * c3_reg;
    assign qe_prod = c1c2_reg * s3_reg;
    assign qf_prod = s1s2_reg * c3_reg;
    assign qg_prod = s1s2_reg * s3_reg;
    assign qh_prod = c1c2_reg * c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg       <= qa_prod[63:30];
        qb_reg       <= qb_prod[63:30];
        qc_reg       <= qc_prod[63:30];
        qd_reg       <= qd_prod[63:30];
        qe_reg       <= qe_prod[63:30];
        qf_reg       <= qf_prod[63:30];
        qg_reg       <= qg_prod[63:30];
        qh_reg       <= qh_prod[63:30];
        roll_s8_reg  <= roll_s7_reg;
        pitch_s8_reg <= pitch_s7_reg;
        yaw_s8_reg   <= yaw_s7_reg;
    end

    // Q30 to Q2.14: round half up, clamp to +-1.0
    function automatic logic signed [15:0] quat_round(input logic signed [34:0] v);
        logic signed [35:0] r;
        logic signed [19:0] q;
        logic signed [15:0] res;
        r = 36'(v) + 36'sd32768;
        q = r[35:16];
        if (q > 20'sd16384)
        begin
            res = 16'sd16384;
        end
        else if (q < -20'sd16384)
        begin
            res = -16'sd16384;
        end
        else
        begin
            res = q[15:0];
        end
        return res;
    endfunction

    // 32-bit binary angle to output angle, round half up, wrapping
    function automatic logic signed [15:0] angle_round(input logic [31:0] a);
        logic [32:0] r;
        r = {1'b0, a} + ANG_ROUND;
        return signed'(16'(r >> ANG_SHIFT));
    endfunction

    // stage 9: output registers
    logic               done_reg;
    logic signed [15:0] roll_out_reg, pitch_out_reg, yaw_out_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        roll_out_reg  <= angle_round(roll_s8_reg);
        pitch_out_reg <= angle_round(pitch_s8_reg);
        yaw_out_reg   <= angle_round(yaw_s8_reg);
        qx_reg        <= quat_round(35'(qa_reg) - 35'(qb_reg));
        qy_reg        <= quat_round(35'(qc_reg) + 35'(qd_reg));
        qz_reg        <= quat_round(35'(qe_reg) - 35'(qf_reg));
        qw_reg        <= quat_round(35'(qg_reg) + 35'(qh_reg));
    end

    assign done        = done_reg;
    assign roll_angle  = roll_out_reg;
    assign pitch_angle = pitch_out_reg;
    assign yaw_angle   = yaw_out_reg;
    assign quat_x      = qx_reg;
    assign quat_y      = qy_reg;
    assign quat_z      = qz_reg;
    assign quat_w      = qw_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // parallel sin/cos pipelines must stay aligned
    a_twin_rot_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rot_r_valid == rot_p_valid)
        else $error("roll/pitch rotation pipelines out of step");

    a_half_rot_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (h1_valid == h2_valid) && (h2_valid == h3_valid))
        else $error("half-angle rotation pipelines out of step");

    // every sample transfer comes out exactly once, as the result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == $past(s0_valid_reg, LATENCY))
        else $error("result strobe does not match sample transfer latency");

    // the clamped quaternion scalar part stays within +-1.0
    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (qw_reg <= 16'sd16384) && (qw_reg >= -16'sd16384))
        else $error("quaternion scalar outside unit range");

endmodule

// ===== tb/attitude_from_accel_mag_checker.sv =====
// attitude_from_accel_mag_checker: watches sample, config and result transfers of the
// compass block, predicts each result and compares it field by field.
// Depends on afam_pkg.
`timescale 1ns / 1ps

module attitude_from_accel_mag_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    input  logic               cfg_write,
    input  logic [afam_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [afam_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic               done,
    input  logic signed [15:0] roll_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output int                 fail_count,
    output int                 pending,
    output int                 heading_count
);

    localparam int STAGES = 16;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [15:0] qw;
    } attitude_t;

    attitude_t attitude_queue[$];
    logic signed [15:0] north_x;
    logic signed [15:0] north_y;

    function automatic longint unsigned atan_of(int k);
        longint unsigned t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1, 1, 0};
        return t[k];
    endfunction

    function automatic longint fmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // atan2(y, x) as 32-bit binary angle, magnitude times gain
    function automatic logic [31:0] atan2_bam(longint x, longint y, output longint len);
        logic [31:0] z;
        longint dx;
        longint dy;
        z = 0;
        len = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = afam_pkg::HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += 32'(atan_of(i));
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= 32'(atan_of(i));
            end
        end
        len = x;
        return z;
    endfunction

    function automatic void cos_sin(logic [31:0] a, output longint c, output longint s);
        logic flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = ((a + afam_pkg::QUARTER_TURN) & afam_pkg::HALF_TURN) != 0;
        x = longint'(afam_pkg::INV_GAIN_Q30);
        y = 0;
        if (flip)
            a += afam_pkg::HALF_TURN;
        z = longint'(signed'(a));
        for (int k = 0; k < STAGES; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_of(k));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_of(k));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic logic [15:0] to_bam16(logic [31:0] a);
        logic [32:0] r;
        r = {1'b0, a} + 33'd32768;
        return r[31:16];
    endfunction

    function automatic logic [31:0] halve(logic [31:0] a);
        return 32'($signed(a) >>> 1);
    endfunction

    function automatic attitude_t predict_attitude(longint ax, longint ay, longint az,
        longint mx, longint my, longint mz, longint rx, longint ry);
        attitude_t r;
        longint m1;
        longint dummy;
        longint cr;
        longint sr;
        longint cp;
        longint sp;
        longint hx;
        longint hy;
        longint c1;
        longint s1;
        longint c2;
        longint s2;
        longint c3;
        longint s3;
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] yaw;
        ax <<<= 16;
        ay <<<= 16;
        az <<<= 16;
        mx <<<= 16;
        my <<<= 16;
        mz <<<= 16;
        roll = atan2_bam(az, ay, m1);
        pitch = atan2_bam(fmul(m1, longint'(afam_pkg::INV_GAIN_Q30)), ax, dummy);
        cos_sin(roll, cr, sr);
        cos_sin(pitch, cp, sp);
        hx = fmul(mx, cp) + fmul(my, fmul(sp, sr)) + fmul(mz, fmul(sp, cr));
        hy = fmul(my, cr) - fmul(mz, sr);
        yaw = atan2_bam(rx * hx + ry * hy, ry * hx - rx * hy, dummy);
        cos_sin(halve(roll), c1, s1);
        cos_sin(halve(pitch), c2, s2);
        cos_sin(halve(yaw), c3, s3);
        r.roll = to_bam16(roll);
        r.pitch = to_bam16(pitch);
        r.yaw = to_bam16(yaw);
        r.qx = to_q14(fmul(fmul(s1, c2), c3) - fmul(fmul(c1, s2), s3));
        r.qy = to_q14(fmul(fmul(s1, c2), s3) + fmul(fmul(c1, s2), c3));
        r.qz = to_q14(fmul(fmul(c1, c2), s3) - fmul(fmul(s1, s2), c3));
        r.qw = to_q14(fmul(fmul(s1, s2), s3) + fmul(fmul(c1, c2), c3));
        return r;
    endfunction

    function automatic void compare(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endfunction

    assign pending = attitude_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        attitude_t want;
        if (!rst_n)
        begin
            north_x <= 16'sd16384;
            north_y <= 16'sd0;
            fail_count = 0;
            heading_count <= 0;
            attitude_queue.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_addr == afam_pkg::REG_NORTH_X)
                    north_x <= cfg_data;
                else if (cfg_addr == afam_pkg::REG_NORTH_Y)
                    north_y <= cfg_data;
            end
            if (start && !busy)
                attitude_queue.push_back(predict_attitude(accel_x, accel_y, accel_z,
                    mag_x, mag_y, mag_z, north_x, north_y));
            if (done)
            begin
                heading_count <= heading_count + 1;
                if (attitude_queue.size() == 0)
                begin
                    $error("result with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    want = attitude_queue.pop_front();
                    compare("roll_angle", want.roll, roll_angle);
                    compare("pitch_angle", want.pitch, pitch_angle);
                    compare("yaw_angle", want.yaw, yaw_angle);
                    compare("quat_x", want.qx, quat_x);
                    compare("quat_y", want.qy, quat_y);
                    compare("quat_z", want.qz, quat_z);
                    compare("quat_w", want.qw, quat_w);
                end
            end
        end
    end

endmodule

// ===== tb/attitude_from_accel_mag_test.sv =====
// attitude_from_accel_mag_test: stimulus and verdict for the compass block.
// Depends on afam_pkg, attitude_from_accel_mag and attitude_from_accel_mag_checker.
`timescale 1ns / 1ps

module attitude_from_accel_mag_test;

    localparam int LATENCY = 99;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic cfg_write;
    logic [afam_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
    logic [afam_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic done;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    int fail_count;
    int pending;
    int heading_count;
    int cycle_count = 0;
    int sample_count;
    int idle_pct;

    attitude_from_accel_mag dut (.*);

    attitude_from_accel_mag_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on a hung or silent block
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // one sample transfer, with a random gap first at the current idle rate
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
        input logic [15:0] az, input logic [15:0] mx, input logic [15:0] my,
        input logic [15:0] mz);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        accel_x <= ax;
        accel_y <= ay;
        accel_z <= az;
        mag_x <= mx;
        mag_y <= my;
        mag_z <= mz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sample_count++;
    endtask

    // every sample gives a result, so an empty queue means the pipe is drained
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_north(input logic [15:0] nx, input logic [15:0] ny);
        cfg_write <= 1'b1;
        cfg_addr <= afam_pkg::REG_NORTH_X;
        cfg_data <= nx;
        @(posedge clk);
        cfg_addr <= afam_pkg::REG_NORTH_Y;
        cfg_data <= ny;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'(10'($urandom())));
            3: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // gravity mostly along z with noise, magnetometer random
    task automatic random_phase(input int count);
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                ax = rand_field();
                ay = rand_field();
                az = rand_field();
            end
            else
            begin
                ax = 16'($signed($urandom_range(8000)) - 4000);
                ay = 16'($signed($urandom_range(8000)) - 4000);
                az = 16'($signed($urandom_range(20000)) - 4000);
            end
            send_sample(ax, ay, az, rand_field(), rand_field(), rand_field());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        mag_x = '0;
        mag_y = '0;
        mag_z = '0;
        cfg_write = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        sample_count = 0;
        idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: level, zero vectors, full-scale extremes, axis flips
        send_sample(0, 0, 16384, 16384, 0, 0);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(0, 0, 16384, 0, 0, 0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(0, 0, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
        send_sample(0, 16'h8000, 0, 0, 16'h8000, 16'h7fff);
        send_sample(16'h7fff, 0, 0, 0, 0, 16'h7fff);
        send_sample(16'h8000, 0, 0, 16'h7fff, 0, 0);
        send_sample(0, 16'hffff, 16'h8000, 0, 1000, 0);
        send_sample(0, 1, 16'h8000, 16'hffff, 0, 0);
        send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_sample(1, 1, 1, 1, 1, 1);
        send_sample(0, 0, 16384, 0, 16384, 0);
        send_sample(0, 0, 16384, 16'hc000, 0, 0);
        send_sample(0, 0, 16384, 0, 16'hc000, 0);
        // wait until every result is in, then the zero reference
        drain();
        write_north(0, 0);
        send_sample(0, 0, 16384, 16384, 0, 0);
        send_sample(300, 200, 16000, 1200, 3000, 16'h8000);
        drain();
        write_north(16'h8000, 16'h8000);
        send_sample(0, 0, 16384, 16384, 5000, 0);
        drain();

        idle_pct = 12;
        write_north(16'h7fff, 16'h8000);
        random_phase(300);
        drain();
        write_north(16'($urandom()), 16'($urandom()));
        random_phase(300);
        drain();

        idle_pct = 77;
        write_north(0, 16'h7fff);
        random_phase(250);
        drain();
        write_north(16'h8000, 0);
        random_phase(250);
        drain();

        idle_pct = 0;
        write_north(16'($urandom()), 16'($urandom()));
        random_phase(300);
        drain();
        write_north(16384, 0);
        random_phase(300);
        drain();
        repeat (LATENCY + 20) @(posedge clk);

        $display("covered %0d samples with %0d results over several north references,",
            sample_count, heading_count);
        $display("including zero vectors, full-scale corners and idle and back-to-back runs");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
